// ----- rtl/three_sum_zero_triples_defines.svh -----
// Assertion macros shared by the three-sum block.
// Included by the controller; depends on nothing.
`ifndef THREE_SUM_ZERO_TRIPLES_DEFINES_SVH
`define THREE_SUM_ZERO_TRIPLES_DEFINES_SVH
// Implication checked on every clock, off during reset.
`define TSZ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("three_sum check failed");
// Next-cycle implication.
`define TSZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("three_sum check failed");
`endif

// ----- rtl/tsz_pkg.sv -----
// Package of the three-sum block: default depth, modes and datapath commands.
// Used by the controller, datapath, top level and testbench; depends on nothing.
package tsz_pkg;
    localparam int DEPTH_DEFAULT = 64;
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // Datapath operations chosen by the controller.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_APPEND  = 4'd1; // store the input value, load result word
    localparam logic [3:0] OP_REJECT  = 4'd2; // store full: load result word only
    localparam logic [3:0] OP_SWAP_LO = 4'd3; // write the smaller entry, hold the larger
    localparam logic [3:0] OP_SWAP_HI = 4'd4; // write the held larger entry
    localparam logic [3:0] OP_OUTER   = 4'd5; // capture the outer value
    localparam logic [3:0] OP_HIT     = 4'd6; // capture the low and high values
    localparam logic [3:0] OP_DONE    = 4'd7; // result word: search exhausted
    localparam logic [3:0] OP_FOUND   = 4'd8; // result word: triple found

    typedef struct packed {
        logic [3:0] op;
    } tsz_cmd_t;
endpackage

// ----- rtl/tsz_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module tsz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ----- rtl/tsz_ctrl.sv -----
// Controller state machine and datapath of the three-sum search.
// Depends on tsz_pkg, tsz_ram and the defines header.
`include "three_sum_zero_triples_defines.svh"
module tsz_ctrl #(
    parameter int DEPTH = tsz_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_mode,
    input  logic                     in_new_set,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tsz_pkg::tsz_cmd_t        cmd,
    output logic [$clog2(DEPTH)-1:0] addr_a,
    output logic [$clog2(DEPTH)-1:0] addr_b,
    output logic [$clog2(DEPTH)-1:0] waddr,
    output logic                     dropped,
    input  logic                     gt_ab,
    input  logic                     eq_ab,
    input  logic                     sum_zero,
    input  logic                     sum_pos,
    input  logic                     match_lo,
    input  logic                     match_hi
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_OUTER = 4'd3;
    localparam logic [3:0] S_ORD   = 4'd4;
    localparam logic [3:0] S_OCHK  = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_SKRD  = 4'd8;
    localparam logic [3:0] S_SKCHK = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_SKRD2 = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sorted_reg, sorted_next, fin_reg, fin_next, ovf_reg, ovf_next;
    logic [CW-1:0] oi_reg, oi_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] si_reg, si_next, sj_reg, sj_next; // insertion sort indices
    logic          skl_reg, skl_next; // skip phase: low side first
    logic          ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign dropped   = ovf_next;

    always_comb
    begin
        state_next = state_reg; cnt_next = cnt_reg; sorted_next = sorted_reg;
        fin_next = fin_reg; ovf_next = ovf_reg; oi_next = oi_reg; lo_next = lo_reg;
        hi_next = hi_reg; si_next = si_reg; sj_next = sj_reg; skl_next = skl_reg;
        ov_next = ov_reg;
        waddr = cnt_reg[AW-1:0];
        addr_a = '0; addr_b = '0; cmd.op = tsz_pkg::OP_NONE;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_mode == tsz_pkg::MODE_LOAD)
                    begin
                        if (in_new_set)
                        begin
                            cnt_next = CW'(1);
                            ovf_next = 1'b0;
                            cmd.op = tsz_pkg::OP_APPEND;
                            waddr = '0;
                        end
                        else if (cnt_reg < FULL)
                        begin
                            cnt_next = cnt_reg + CW'(1);
                            cmd.op = tsz_pkg::OP_APPEND;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                            cmd.op = tsz_pkg::OP_REJECT;
                        end
                        sorted_next = 1'b0;
                        fin_next = 1'b0;
                        oi_next = '0;
                        ov_next = 1'b1;
                    end
                    else if (!sorted_reg)
                    begin
                        si_next = CW'(1);
                        sj_next = CW'(1);
                        state_next = S_SRD;
                    end
                    else
                    begin
                        state_next = S_OUTER;
                    end
                end
            end
            // Insertion sort by adjacent swaps: compare j-1 and j.
            S_SRD:
            begin
                if (si_reg >= cnt_reg)
                begin
                    sorted_next = 1'b1;
                    fin_next = 1'b0;
                    oi_next = '0;
                    lo_next = CW'(1);
                    hi_next = (cnt_reg != '0) ? cnt_reg - CW'(1) : '0;
                    state_next = S_OUTER;
                end
                else if (sj_reg == '0)
                begin
                    si_next = si_reg + CW'(1);
                    sj_next = si_reg + CW'(1);
                end
                else
                begin
                    addr_a = AW'(sj_reg - CW'(1));
                    addr_b = AW'(sj_reg);
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (gt_ab)
                begin
                    // Swap: the smaller entry is written now, the larger one next.
                    cmd.op = tsz_pkg::OP_SWAP_LO;
                    waddr = AW'(sj_reg - CW'(1));
                    state_next = S_SKRD2;
                end
                else
                begin
                    si_next = si_reg + CW'(1);
                    sj_next = si_reg + CW'(1);
                    state_next = S_SRD;
                end
            end
            S_SKRD2:
            begin
                cmd.op = tsz_pkg::OP_SWAP_HI;
                waddr = AW'(sj_reg);
                sj_next = sj_reg - CW'(1);
                state_next = S_SRD;
            end
            S_OUTER:
            begin
                if (fin_reg || cnt_reg < CW'(3) || (oi_reg + CW'(2)) >= cnt_reg)
                begin
                    fin_next = 1'b1;
                    cmd.op = tsz_pkg::OP_DONE;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_a = AW'(oi_reg);
                    addr_b = AW'((oi_reg != '0) ? oi_reg - CW'(1) : oi_reg);
                    state_next = S_OCHK;
                end
            end
            S_OCHK:
            begin
                cmd.op = tsz_pkg::OP_OUTER;
                if (oi_reg != '0 && eq_ab)
                begin
                    oi_next = oi_reg + CW'(1);
                    lo_next = oi_reg + CW'(2);
                    hi_next = cnt_reg - CW'(1);
                    state_next = S_OUTER;
                end
                else
                begin
                    state_next = S_LRD;
                end
            end
            S_LRD:
            begin
                if (lo_reg >= hi_reg || hi_reg >= cnt_reg)
                begin
                    oi_next = oi_reg + CW'(1);
                    lo_next = oi_reg + CW'(2);
                    hi_next = cnt_reg - CW'(1);
                    state_next = S_OUTER;
                end
                else
                begin
                    addr_a = AW'(lo_reg);
                    addr_b = AW'(hi_reg);
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (sum_zero)
                begin
                    cmd.op = tsz_pkg::OP_HIT;
                    lo_next = lo_reg + CW'(1);
                    hi_next = hi_reg - CW'(1);
                    skl_next = 1'b1;
                    state_next = S_SKRD;
                end
                else if (sum_pos)
                begin
                    hi_next = hi_reg - CW'(1);
                    state_next = S_LRD;
                end
                else
                begin
                    lo_next = lo_reg + CW'(1);
                    state_next = S_LRD;
                end
            end
            // Step past equal neighbours, low pointer first, then high.
            S_SKRD:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    addr_a = AW'(skl_reg ? lo_reg : hi_reg);
                    state_next = S_SKCHK;
                end
            end
            S_SKCHK:
            begin
                if (skl_reg)
                begin
                    if (match_lo)
                    begin
                        lo_next = lo_reg + CW'(1);
                    end
                    else
                    begin
                        skl_next = 1'b0;
                    end
                    state_next = S_SKRD;
                end
                else if (match_hi)
                begin
                    hi_next = hi_reg - CW'(1);
                    state_next = S_SKRD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.op = tsz_pkg::OP_FOUND;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; cnt_reg <= '0; sorted_reg <= 1'b0; fin_reg <= 1'b0;
            ovf_reg <= 1'b0; oi_reg <= '0; lo_reg <= '0; hi_reg <= '0;
            si_reg <= '0; sj_reg <= '0; skl_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; cnt_reg <= cnt_next; sorted_reg <= sorted_next;
            fin_reg <= fin_next; ovf_reg <= ovf_next; oi_reg <= oi_next;
            lo_reg <= lo_next; hi_reg <= hi_next; si_reg <= si_next;
            sj_reg <= sj_next; skl_reg <= skl_next; ov_reg <= ov_next;
        end
    end

    `TSZ_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= FULL)
    `TSZ_ASSERT_NEXT(a_load_out, in_valid && in_ready && in_mode == tsz_pkg::MODE_LOAD,
                     out_valid)
    `TSZ_ASSERT_IMP(a_ready_excl, out_valid, !in_ready)
    `TSZ_ASSERT_IMP(a_ptr_order, state_reg == S_SUM, lo_reg < hi_reg && hi_reg < cnt_reg)
endmodule

// Datapath: value store, captured triple values, comparators and result word.
module tsz_dp #(
    parameter int DEPTH = tsz_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  tsz_pkg::tsz_cmd_t        cmd,
    input  logic [$clog2(DEPTH)-1:0] addr_a,
    input  logic [$clog2(DEPTH)-1:0] addr_b,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [31:0]              in_value,
    input  logic                     dropped,
    output logic                     gt_ab,
    output logic                     eq_ab,
    output logic                     sum_zero,
    output logic                     sum_pos,
    output logic                     match_lo,
    output logic                     match_hi,
    output logic [98:0]              out_word
);
    logic          we;
    logic [31:0]   wd, da, db;
    logic [31:0]   t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [98:0]   ow_reg, ow_next;
    logic signed [33:0] sum;

    tsz_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd),
        .raddr_a(addr_a), .raddr_b(addr_b), .rdata_a(da), .rdata_b(db)
    );

    // The three-way sum needs 34 bits so that it never wraps.
    assign sum = 34'(signed'(t0_reg)) + 34'(signed'(da)) + 34'(signed'(db));

    assign gt_ab    = signed'(da) > signed'(db);
    assign eq_ab    = (da == db);
    assign sum_zero = (sum == '0);
    assign sum_pos  = (sum > 34'sd0);
    assign match_lo = (da == t1_reg);
    assign match_hi = (da == t2_reg);
    assign out_word = ow_reg;

    function automatic logic [98:0] pack_out(logic f, logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c, logic e, logic d);
        return {d, e, c, b, a, f};
    endfunction

    always_comb
    begin
        we = 1'b0; wd = in_value;
        t0_next = t0_reg; t1_next = t1_reg; t2_next = t2_reg; ow_next = ow_reg;
        case (cmd.op)
            tsz_pkg::OP_APPEND:
            begin
                we = 1'b1;
                ow_next = pack_out(1'b0, '0, '0, '0, 1'b0, dropped);
            end
            tsz_pkg::OP_REJECT:
            begin
                ow_next = pack_out(1'b0, '0, '0, '0, 1'b0, dropped);
            end
            tsz_pkg::OP_SWAP_LO:
            begin
                we = 1'b1;
                wd = db;
                t1_next = da;
            end
            tsz_pkg::OP_SWAP_HI:
            begin
                we = 1'b1;
                wd = t1_reg;
            end
            tsz_pkg::OP_OUTER:
            begin
                t0_next = da;
            end
            tsz_pkg::OP_HIT:
            begin
                t1_next = da;
                t2_next = db;
            end
            tsz_pkg::OP_DONE:
            begin
                ow_next = pack_out(1'b0, '0, '0, '0, 1'b1, dropped);
            end
            tsz_pkg::OP_FOUND:
            begin
                ow_next = pack_out(1'b1, t0_reg, t1_reg, t2_reg, 1'b0, dropped);
            end
            default:
            begin
                ow_next = ow_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        t0_reg <= t0_next; t1_reg <= t1_next; t2_reg <= t2_next; ow_reg <= ow_next;
    end
endmodule

// ----- rtl/three_sum_zero_triples.sv -----
// Top level of the three-sum zero-triple finder.
// Depends on tsz_pkg and on tsz_ctrl and tsz_dp.
//
// Channel   Direction  Contents (tdata from bit 0 up)
// s_axis    in         mode, value[31:0], new_set (34 bits, padded to 40)
// m_axis    out        found, smallest, middle, largest, exhausted, dropped (99 -> 104)
//
// A load's result word is valid in the cycle after the load is accepted. A fetch after
// a load first runs an insertion sort over the store, then walks the pointers; each
// pointer step reads its pair of values through the registered dual-read RAM.
// Reset clears the count and flags; the store contents need no clearing. A stalled
// result holds the block: the next word is accepted only after the result is taken.
module three_sum_zero_triples #(
    parameter int DEPTH = tsz_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // mode, value[31:0], new_set, zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata   // found, smallest, middle, largest, exhausted, dropped
);
    logic [98:0] word;

    // Command and status signals between the controller and the datapath.
    tsz_pkg::tsz_cmd_t          cmd;
    logic [$clog2(DEPTH)-1:0]   addr_a, addr_b, waddr;
    logic                       dropped;
    logic                       gt_ab, eq_ab, sum_zero, sum_pos, match_lo, match_hi;

    tsz_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_mode(s_axis_tdata[0]), .in_new_set(s_axis_tdata[33]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .addr_a(addr_a), .addr_b(addr_b), .waddr(waddr), .dropped(dropped),
        .gt_ab(gt_ab), .eq_ab(eq_ab), .sum_zero(sum_zero), .sum_pos(sum_pos),
        .match_lo(match_lo), .match_hi(match_hi)
    );

    tsz_dp #(.DEPTH(DEPTH)) u_dp (
        .clk(clk), .cmd(cmd), .addr_a(addr_a), .addr_b(addr_b), .waddr(waddr),
        .in_value(s_axis_tdata[32:1]), .dropped(dropped),
        .gt_ab(gt_ab), .eq_ab(eq_ab), .sum_zero(sum_zero), .sum_pos(sum_pos),
        .match_lo(match_lo), .match_hi(match_hi), .out_word(word)
    );

    assign m_axis_tdata = {5'd0, word};
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the three-sum zero-triple finder.
// Loads value sets, fetches triples and compares every result word with a
// behavioral model of the sort and two-pointer search. Depends on tsz_pkg and the RTL.
module testbench;
    localparam int DEPTH = tsz_pkg::DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic        new_set;
        logic [31:0] value;
        logic        mode;
    } word_in_t;

    typedef struct packed {
        logic        dropped;
        logic        exhausted;
        logic [31:0] largest;
        logic [31:0] middle;
        logic [31:0] smallest;
        logic        found;
    } word_out_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    three_sum_zero_triples #(.DEPTH(DEPTH)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Predictor state: a shadow of the block's store and search pointers.
    logic signed [31:0] shadow_store [DEPTH];
    int  shadow_count;
    bit  shadow_sorted;
    int  outer_idx;
    int  low_ptr;
    int  high_ptr;
    bit  search_done;
    bit  shadow_overflow;

    word_in_t  pending_words [$];
    word_out_t expected_results [$];
    int  pause_after [$];   // index of words after which the sender waits for drain
    int  error_count = 0;
    int  sent_count = 0;
    bit  stimulus_done = 0;

    function automatic void queue_word(word_in_t w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void restart_outer(int i);
        outer_idx = i;
        low_ptr = i + 1;
        high_ptr = (shadow_count > 0) ? shadow_count - 1 : 0;
    endfunction

    function automatic void sort_shadow();
        logic signed [31:0] key;
        int j;
        for (int i = 1; i < shadow_count; i++)
        begin
            key = shadow_store[i];
            j = i;
            while (j > 0 && shadow_store[j-1] > key)
            begin
                shadow_store[j] = shadow_store[j-1];
                j--;
            end
            shadow_store[j] = key;
        end
    endfunction

    // Resumes the two-pointer search; returns 1 with the triple on a hit.
    function automatic bit search_next(output logic signed [31:0] a, b, c);
        longint sum;
        a = 0;
        b = 0;
        c = 0;
        while (!search_done)
        begin
            if (shadow_count < 3 || outer_idx + 2 >= shadow_count)
            begin
                search_done = 1;
                break;
            end
            if (outer_idx > 0 && shadow_store[outer_idx] == shadow_store[outer_idx-1])
            begin
                restart_outer(outer_idx + 1);
                continue;
            end
            if (low_ptr >= high_ptr || high_ptr >= shadow_count)
            begin
                restart_outer(outer_idx + 1);
                continue;
            end
            sum = longint'(shadow_store[outer_idx]) + longint'(shadow_store[low_ptr])
                + longint'(shadow_store[high_ptr]);
            if (sum == 0)
            begin
                a = shadow_store[outer_idx];
                b = shadow_store[low_ptr];
                c = shadow_store[high_ptr];
                low_ptr++;
                while (low_ptr < high_ptr && shadow_store[low_ptr] == shadow_store[low_ptr-1])
                    low_ptr++;
                high_ptr--;
                while (low_ptr < high_ptr && shadow_store[high_ptr] == shadow_store[high_ptr+1])
                    high_ptr--;
                return 1;
            end
            else if (sum > 0)
                high_ptr--;
            else
                low_ptr++;
        end
        return 0;
    endfunction

    function automatic word_out_t predict_result(word_in_t w);
        word_out_t r;
        logic signed [31:0] a, b, c;
        bit hit;
        r = '0;
        if (w.mode == tsz_pkg::MODE_LOAD)
        begin
            if (w.new_set)
            begin
                shadow_count = 0;
                shadow_overflow = 0;
            end
            if (shadow_count < DEPTH)
            begin
                shadow_store[shadow_count] = w.value;
                shadow_count++;
            end
            else
                shadow_overflow = 1;
            shadow_sorted = 0;
            search_done = 0;
            restart_outer(0);
        end
        else
        begin
            if (!shadow_sorted)
            begin
                sort_shadow();
                shadow_sorted = 1;
                search_done = 0;
                restart_outer(0);
            end
            hit = search_next(a, b, c);
            r.found = hit;
            r.smallest = a;
            r.middle = b;
            r.largest = c;
            r.exhausted = !hit;
        end
        r.dropped = shadow_overflow;
        return r;
    endfunction

    function automatic word_in_t make_word(logic mode, logic [31:0] value, logic new_set);
        word_in_t w;
        w.mode = mode;
        w.value = value;
        w.new_set = new_set;
        return w;
    endfunction

    // Values drawn mostly from a small pool so that zero sums and repeats are common.
    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return 32'($signed($urandom_range(0, 12)) - 6);
        else if (k < 8)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h8000_0001;
                default: return 32'h0000_0001;
            endcase
        end
        else
            return $urandom;
    endfunction

    // Stimulus: directed sets first, then random sets with fetch bursts.
    initial
    begin
        int n;
        int fetches;
        int wide;
        // Edge-value set: MIN + MAX + 1 = 0, and the 34-bit sum must not wrap.
        queue_word(make_word(tsz_pkg::MODE_FETCH, 32'd0, 1'b1)); // empty set, new_set ignored
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'h8000_0000, 1'b1));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'h7FFF_FFFF, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_FETCH, 32'd0, 1'b0)); // fewer than three values
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'h0000_0001, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'h7FFF_FFFF, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'h7FFF_FFFF, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_FETCH, 32'd0, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_FETCH, 32'd0, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_FETCH, 32'd0, 1'b0));
        // Repeated values: zeros and -1,-1,2 duplicates.
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'd0, 1'b1));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'd0, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'd0, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'd0, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'hFFFF_FFFF, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'hFFFF_FFFF, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'd2, 1'b0));
        queue_word(make_word(tsz_pkg::MODE_LOAD, 32'd1, 1'b0));
        for (int i = 0; i < 5; i++)
            queue_word(make_word(tsz_pkg::MODE_FETCH, 32'hFFFF_FFFF, 1'b1));
        pause_after = {pause_after, pending_words.size()};

        // Random sets: well-formed load-then-fetch runs, with occasional noise.
        while (pending_words.size() < 800)
        begin
            wide = ($urandom_range(0, 19) == 0);
            n = wide ? $urandom_range(60, 66) : $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                queue_word(make_word(tsz_pkg::MODE_LOAD, pick_value(),
                    (i == 0) ? 1'b1 : 1'b0));
            fetches = $urandom_range(1, 8);
            for (int i = 0; i < fetches; i++)
            begin
                queue_word(make_word(tsz_pkg::MODE_FETCH, $urandom,
                    1'($urandom_range(0, 1))));
                if ($urandom_range(0, 9) == 0)
                    queue_word(make_word(tsz_pkg::MODE_LOAD, pick_value(),
                        1'($urandom_range(0, 1))));
            end
        end
        stimulus_done = 1;
    end

    // Driver: waits a drawn gap after each word, and drains at marked points.
    int gap_left;
    int pause_ix;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            gap_left <= 0;
            pause_ix <= 0;
        end
        else if (s_axis_tvalid && !s_axis_tready)
        begin
            // Word still waiting for acceptance.
        end
        else
        begin
            if (s_axis_tvalid)
                sent_count <= sent_count + 1;
            if (pause_ix < pause_after.size() && sent_count + s_axis_tvalid
                == pause_after[pause_ix] && expected_results.size() != 0)
                s_axis_tvalid <= 1'b0;
            else if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_words.size() != 0)
            begin
                word_in_t w;
                if (pause_ix < pause_after.size()
                    && sent_count + s_axis_tvalid == pause_after[pause_ix])
                    pause_ix <= pause_ix + 1;
                w = pending_words.pop_front();
                expected_results = {expected_results, predict_result(w)};
                s_axis_tdata <= {6'b0, w};
                s_axis_tvalid <= 1'b1;
                gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: random back-pressure, then field-by-field comparison.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                word_out_t got;
                word_out_t want;
                got = m_axis_tdata[98:0];
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        error_count++;
                    end
                    if (got.smallest !== want.smallest)
                    begin
                        $error("smallest: expected %0d, got %0d",
                            $signed(want.smallest), $signed(got.smallest));
                        error_count++;
                    end
                    if (got.middle !== want.middle)
                    begin
                        $error("middle: expected %0d, got %0d",
                            $signed(want.middle), $signed(got.middle));
                        error_count++;
                    end
                    if (got.largest !== want.largest)
                    begin
                        $error("largest: expected %0d, got %0d",
                            $signed(want.largest), $signed(got.largest));
                        error_count++;
                    end
                    if (got.exhausted !== want.exhausted)
                    begin
                        $error("exhausted: expected %0d, got %0d",
                            want.exhausted, got.exhausted);
                        error_count++;
                    end
                    if (got.dropped !== want.dropped)
                    begin
                        $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready && $urandom_range(0, 3) == 0)
                    stall_left <= $urandom_range(0, 16);
            end
        end
    end

    // Watchdog on cycles without any accepted word; the limit leaves a wide margin
    // for a full sort of 64 values.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done);
        wait (pending_words.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- three_sum_zero_triples.f -----
+incdir+rtl
rtl/tsz_pkg.sv
rtl/tsz_ram.sv
rtl/tsz_ctrl.sv
rtl/three_sum_zero_triples.sv
test/testbench.sv
